// ===== design/bpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer pool allocator package
// Request and response payloads, operation and status codes, sequencer states
// and the command interface of the shared multiply/divide unit.
// ----------------------------------------------------------------------------
package bpa_pkg;

  typedef struct packed {
    logic [2:0]  action;
    logic        any_pool;
    logic [8:0]  pool_id;
    logic [31:0] handle;
    logic [63:0] block_size;
    logic [15:0] block_count;
    logic [1:0]  pool_kind;
    logic [63:0] base_address;
    logic [63:0] phys_address;
    logic [7:0]  owner_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [24:0] value;
    logic [63:0] address_out;
    logic [63:0] size_out;
    logic [15:0] count_out;
    logic [63:0] total_out;
    logic        is_common;
  } rsp_t;

  localparam logic [2:0] ACT_CREATE   = 3'd0;
  localparam logic [2:0] ACT_DESTROY  = 3'd1;
  localparam logic [2:0] ACT_GET      = 3'd2;
  localparam logic [2:0] ACT_RELEASE  = 3'd3;
  localparam logic [2:0] ACT_A2H      = 3'd4;
  localparam logic [2:0] ACT_H2A      = 3'd5;
  localparam logic [2:0] ACT_H2P      = 3'd6;
  localparam logic [2:0] ACT_INFO     = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;

  localparam logic [31:0] HANDLE_LIMIT = 32'h01ff_ffff;
  localparam logic [7:0]  OWNER_LIMIT  = 8'h17;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD,
    S_CHK,
    S_BSCAN,
    S_AWAIT,
    S_MULW,
    S_FIND,
    S_CWR,
    S_FINISH
  } state_t;

  // Shared arithmetic unit: 64 x 16 multiply or 64 / 64 divide, 16-bit quotient.
  typedef struct packed {
    logic        start;
    logic        div;
    logic [63:0] a;
    logic [63:0] b;
  } arith_cmd_t;

  typedef struct packed {
    logic        done;
    logic [79:0] result;
  } arith_rsp_t;

endpackage

// ===== design/bpa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/bpa_arith.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiply/divide unit
// One 81-bit adder steps a shift-add multiply or a restoring divide, one bit
// of the 16-bit multiplier or quotient per cycle.
// ----------------------------------------------------------------------------
module bpa_arith (
  input  logic                clk,
  input  logic                rst,
  input  bpa_pkg::arith_cmd_t cmd,
  output bpa_pkg::arith_rsp_t rsp
);
  import bpa_pkg::*;

  logic        busy;
  logic        div;
  logic [3:0]  cnt;
  logic [79:0] acc;
  logic [79:0] dreg;
  logic [15:0] mreg;
  logic        done;

  logic [79:0] x;
  logic [79:0] addend;
  logic [80:0] sum;

  always_comb begin
    x      = div ? acc : {acc[78:0], 1'b0};
    addend = (div || mreg[15]) ? dreg : '0;
    sum    = {1'b0, x} + {1'b0, (div ? ~addend : addend)} + 81'(div);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        div  <= cmd.div;
        cnt  <= 4'd15;
        if (cmd.div) begin
          acc  <= {16'b0, cmd.a};
          dreg <= {16'b0, cmd.b} << 15;
          mreg <= '0;
        end else begin
          acc  <= '0;
          dreg <= {16'b0, cmd.a};
          mreg <= cmd.b[15:0];
        end
      end else if (busy) begin
        if (div) begin
          // The carry out says the shifted divisor fit into the remainder.
          if (sum[80]) begin
            acc <= sum[79:0];
          end
          mreg <= {mreg[14:0], sum[80]};
          dreg <= dreg >> 1;
        end else begin
          acc  <= sum[79:0];
          mreg <= {mreg[14:0], 1'b0};
        end
        cnt <= cnt - 4'd1;
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = div ? {64'b0, mreg} : acc;

endmodule

// ===== design/buffer_pool_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer pool block allocator
// Pool table with per-pool free bitmaps, driven by a small sequencer.
// ----------------------------------------------------------------------------
// Requests enter on req/req_valid/req_ready and each gives one response on
// rsp/rsp_valid/rsp_ready. One request is worked on at a time; req_ready is
// high only while the sequencer is idle. Pool data and free bitmaps live in
// two single-port RAMs, so every pool visited takes an address step, then a
// check step. Products and quotients come from one shared unit. Steps per
// operation, excluding the response wait:
//   create: size check multiply, then free slot scan
//   get block: pool check or pool scan, then the free bit search, taking one
//     bit a cycle
//   addr_to_handle: pool scan, then divide; handle_to_addr: check, then multiply
// At reset all pools are marked unused; no clearing pass is needed. A finished
// response is held in an output register, and the next request is taken while
// it waits; a stalled receiver holds up only the following completion.
// ----------------------------------------------------------------------------
module buffer_pool_block_allocator #(
  parameter int NUM_POOLS  = 16,
  parameter int MAX_BLOCKS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bpa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bpa_pkg::rsp_t rsp
);
  import bpa_pkg::*;

  localparam int PW     = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int BW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW     = $clog2(MAX_BLOCKS + 1);
  localparam int META_W = 64 + 64 + CW + 1 + 64;
  localparam int COM_B  = 64;
  localparam int CNT_L  = 65;
  localparam int SIZE_L = 65 + CW;
  localparam int BASE_L = 129 + CW;

  state_t state, state_next;
  req_t   req_q;
  rsp_t   res;
  rsp_t   rsp_q;
  logic [NUM_POOLS-1:0] used;
  logic [PW-1:0]        slot;
  logic [BW-1:0]        bidx;

  logic                  meta_we, bits_we;
  logic [META_W-1:0]     meta_wdata, meta_rd;
  logic [MAX_BLOCKS-1:0] bits_wdata, bits_rd;
  logic [MAX_BLOCKS-1:0] create_mask;

  arith_cmd_t arith_cmd;
  arith_rsp_t arith_rsp;

  logic [63:0]   m_base, m_size, m_total;
  logic [CW-1:0] m_count;
  logic          m_common;
  logic [8:0]    hp;
  logic [15:0]   hidx;
  logic [63:0]   offset;
  logic create_bad, pid_ok, h_ok, hp_ok, owner_bad, fits, has_free;
  logic in_range, idx_in, slot_last, bit_hit, pool_hit, mul_ovf;

  bpa_ram #(.WIDTH(META_W), .DEPTH(NUM_POOLS)) u_meta_ram (
    .clk(clk), .we(meta_we), .addr(slot), .wdata(meta_wdata), .rdata(meta_rd)
  );

  bpa_ram #(.WIDTH(MAX_BLOCKS), .DEPTH(NUM_POOLS)) u_bits_ram (
    .clk(clk), .we(bits_we), .addr(slot), .wdata(bits_wdata), .rdata(bits_rd)
  );

  bpa_arith u_arith (.clk(clk), .rst(rst), .cmd(arith_cmd), .rsp(arith_rsp));

  always_comb begin
    m_total  = meta_rd[63:0];
    m_common = meta_rd[COM_B];
    m_count  = meta_rd[CNT_L +: CW];
    m_size   = meta_rd[SIZE_L +: 64];
    m_base   = meta_rd[BASE_L +: 64];
    hp       = req_q.handle[24:16];
    hidx     = req_q.handle[15:0];
    offset   = req_q.phys_address - m_base;

    create_bad = (req_q.block_size == 64'd0) || (req_q.block_count == 16'd0) ||
                 (req_q.block_count > 16'(MAX_BLOCKS));
    pid_ok    = (10'(req_q.pool_id) < 10'(NUM_POOLS)) && used[req_q.pool_id[PW-1:0]];
    h_ok      = req_q.handle <= HANDLE_LIMIT;
    hp_ok     = (10'(hp) < 10'(NUM_POOLS)) && used[hp[PW-1:0]];
    owner_bad = req_q.owner_id > OWNER_LIMIT;
    fits      = (req_q.block_size == 64'd0) || (req_q.block_size <= m_size);
    has_free  = |bits_rd;
    pool_hit  = used[slot] && fits && has_free;
    in_range  = used[slot] && (req_q.phys_address >= m_base) && (offset < m_total);
    idx_in    = hidx < 16'(m_count);
    slot_last = slot == PW'(NUM_POOLS - 1);
    bit_hit   = bits_rd[bidx];
    mul_ovf   = arith_rsp.result[79:64] != 16'd0;

    for (int i = 0; i < MAX_BLOCKS; i++) begin
      create_mask[i] = 32'(i) < 32'(req_q.block_count);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (req_q.action)
          ACT_CREATE:  state_next = create_bad ? S_FINISH : S_MULW;
          ACT_DESTROY: state_next = S_FINISH;
          ACT_GET: begin
            if (owner_bad)               state_next = S_FINISH;
            else if (req_q.any_pool || pid_ok) state_next = S_RD;
            else                          state_next = S_FINISH;
          end
          ACT_RELEASE, ACT_H2A: state_next = (h_ok && hp_ok) ? S_RD : S_FINISH;
          ACT_A2H:     state_next = S_RD;
          ACT_H2P:     state_next = S_FINISH;
          default:     state_next = pid_ok ? S_RD : S_FINISH;
        endcase
      end
      S_RD: state_next = S_CHK;
      S_CHK: begin
        unique case (req_q.action)
          ACT_GET: begin
            if (req_q.any_pool) begin
              if (pool_hit)       state_next = S_BSCAN;
              else if (slot_last) state_next = S_FINISH;
              else                state_next = S_RD;
            end else begin
              state_next = (fits && has_free) ? S_BSCAN : S_FINISH;
            end
          end
          ACT_A2H: begin
            if (in_range)       state_next = S_AWAIT;
            else if (slot_last) state_next = S_FINISH;
            else                state_next = S_RD;
          end
          ACT_H2A: state_next = idx_in ? S_AWAIT : S_FINISH;
          default: state_next = S_FINISH;
        endcase
      end
      S_BSCAN: begin
        if (bit_hit) state_next = S_FINISH;
      end
      S_AWAIT: begin
        if (arith_rsp.done) state_next = S_FINISH;
      end
      S_MULW: begin
        if (arith_rsp.done) state_next = mul_ovf ? S_FINISH : S_FIND;
      end
      S_FIND: begin
        if (!used[slot])    state_next = S_CWR;
        else if (slot_last) state_next = S_FINISH;
      end
      S_CWR: state_next = S_FINISH;
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs to the RAMs and the arithmetic unit
  always_comb begin
    req_ready  = state == S_IDLE;
    meta_we    = state == S_CWR;
    meta_wdata = {req_q.base_address, req_q.block_size, req_q.block_count[CW-1:0],
                  (req_q.pool_kind != 2'd0), arith_rsp.result[63:0]};
    bits_we    = 1'b0;
    bits_wdata = create_mask;
    arith_cmd  = '0;
    unique case (state)
      S_DECODE: begin
        if (req_q.action == ACT_CREATE && !create_bad) begin
          arith_cmd.start = 1'b1;
          arith_cmd.a     = req_q.block_size;
          arith_cmd.b     = 64'(req_q.block_count);
        end
      end
      S_CHK: begin
        if (req_q.action == ACT_RELEASE && idx_in) begin
          bits_we    = 1'b1;
          bits_wdata = bits_rd | (MAX_BLOCKS'(1) << hidx);
        end
        if (req_q.action == ACT_A2H && in_range) begin
          arith_cmd.start = 1'b1;
          arith_cmd.div   = 1'b1;
          arith_cmd.a     = offset;
          arith_cmd.b     = m_size;
        end
        if (req_q.action == ACT_H2A && idx_in) begin
          arith_cmd.start = 1'b1;
          arith_cmd.a     = m_size;
          arith_cmd.b     = 64'(hidx);
        end
      end
      S_BSCAN: begin
        bits_we    = bit_hit;
        bits_wdata = bits_rd & ~(MAX_BLOCKS'(1) << bidx);
      end
      S_CWR: bits_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      // A new response may replace the one being taken in the same cycle.
      if (state == S_FINISH && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            res   <= '0;
          end
        end
        S_DECODE: begin
          unique case (req_q.action)
            ACT_CREATE: begin
              if (create_bad) res.status <= ST_INVALID;
            end
            ACT_DESTROY: begin
              if (pid_ok) used[req_q.pool_id[PW-1:0]] <= 1'b0;
              else        res.status <= ST_INVALID;
            end
            ACT_GET: begin
              if (owner_bad)           res.status <= ST_INVALID;
              else if (req_q.any_pool) slot <= '0;
              else if (pid_ok)         slot <= req_q.pool_id[PW-1:0];
              else                     res.status <= ST_INVALID;
            end
            ACT_RELEASE, ACT_H2A: begin
              if (h_ok && hp_ok) slot <= hp[PW-1:0];
              else               res.status <= ST_INVALID;
            end
            ACT_A2H: slot <= '0;
            ACT_H2P: begin
              if (h_ok) res.value  <= 25'(hp);
              else      res.status <= ST_INVALID;
            end
            default: begin
              if (pid_ok) slot <= req_q.pool_id[PW-1:0];
              else        res.status <= ST_INVALID;
            end
          endcase
        end
        S_CHK: begin
          bidx <= '0;
          unique case (req_q.action)
            ACT_GET: begin
              if (req_q.any_pool) begin
                if (!pool_hit) begin
                  if (slot_last) res.status <= ST_INVALID;
                  else           slot <= slot + PW'(1);
                end
              end else if (!fits) begin
                res.status <= ST_INVALID;
              end else if (!has_free) begin
                res.status <= ST_NOSPACE;
              end
            end
            ACT_A2H: begin
              if (!in_range) begin
                if (slot_last) res.status <= ST_INVALID;
                else           slot <= slot + PW'(1);
              end
            end
            ACT_H2A: begin
              if (!idx_in) res.status <= ST_INVALID;
            end
            ACT_INFO: begin
              res.address_out <= m_base;
              res.size_out    <= m_size;
              res.count_out   <= 16'(m_count);
              res.total_out   <= m_total;
              res.is_common   <= m_common;
            end
            default: ;
          endcase
        end
        S_BSCAN: begin
          if (bit_hit) res.value <= {9'(slot), 16'(bidx)};
          else         bidx <= bidx + BW'(1);
        end
        S_AWAIT: begin
          if (arith_rsp.done) begin
            if (req_q.action == ACT_A2H) begin
              res.value <= {9'(slot), arith_rsp.result[15:0]};
            end else begin
              res.address_out <= m_base + arith_rsp.result[63:0];
            end
          end
        end
        S_MULW: begin
          if (arith_rsp.done) begin
            if (mul_ovf) res.status <= ST_INVALID;
            slot <= '0;
          end
        end
        S_FIND: begin
          if (used[slot]) begin
            if (slot_last) res.status <= ST_NOSPACE;
            else           slot <= slot + PW'(1);
          end
        end
        S_CWR: begin
          used[slot] <= 1'b1;
          res.value  <= 25'(slot);
        end
        S_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_q <= res;
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp = rsp_q;

  // The shared unit is started only from the decode or check step.
  a_arith_start: assert property (@(posedge clk) disable iff (rst)
    arith_cmd.start |-> (state == S_DECODE || state == S_CHK))
    else $error("arithmetic unit started outside decode or check");

  // A bitmap write always targets a slot that is in use or being created.
  a_bits_write: assert property (@(posedge clk) disable iff (rst)
    bits_we |-> (used[slot] || state == S_CWR))
    else $error("free bitmap written for an unused pool");

  // Leaving the finish step always presents a response.
  a_finish_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && (!rsp_valid || rsp_ready)) |=> (rsp_valid && state == S_IDLE))
    else $error("finish step did not produce a response");

  // A granted block index is always inside the pool.
  a_grant_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_BSCAN && bit_hit) |-> ((CW+1)'(bidx) < (CW+1)'(m_count)))
    else $error("granted block beyond the pool's block count");

endmodule

// ===== tb/buffer_pool_block_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer pool block allocator testbench
// Drives pool requests through the valid/ready handshake, predicts every
// response with a behavioral pool table and compares all response fields.
// Random gaps on both channels, a long response stall and a full drain.
// ----------------------------------------------------------------------------
module buffer_pool_block_allocator_test;
  import bpa_pkg::*;

  localparam int NPOOL = 16;
  localparam int NBLK  = 64;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  buffer_pool_block_allocator #(.NUM_POOLS(NPOOL), .MAX_BLOCKS(NBLK)) u_top (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
    .req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Pool table mirror.
  logic        pool_used [NPOOL];
  logic [63:0] pool_base [NPOOL];
  logic [63:0] pool_bsize [NPOOL];
  logic [6:0]  pool_bcount [NPOOL];
  logic        pool_common [NPOOL];
  logic [63:0] pool_free [NPOOL];

  rsp_t pending_rsp[$];
  int   errors;
  int   rsp_seen;
  int   req_sent;
  int   idle_cycles;
  bit   hold_off;
  bit   timed_out;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
    $display("MISMATCH %s: got %h expected %h (response %0d)", what, got, exp, rsp_seen);
    errors++;
  endtask

  function automatic int first_free_block(input int p);
    int i;
    for (i = 0; i < pool_bcount[p]; i++)
      if (pool_free[p][i]) return i;
    return pool_bcount[p];
  endfunction

  function automatic bit known_pool(input logic [31:0] id);
    return id < NPOOL && pool_used[id];
  endfunction

  function automatic rsp_t predict_pool_op(input req_t r);
    rsp_t o;
    int p;
    int i;
    bit found;
    logic [127:0] prod;
    logic [63:0] off;
    o = '0;
    o.status = ST_OK;
    case (r.action)
      ACT_CREATE: begin
        prod = r.block_size * r.block_count;
        if (r.block_size == 0 || r.block_count == 0 || r.block_count > NBLK ||
            prod[127:64] != 0) begin
          o.status = ST_INVALID;
        end else begin
          found = 0;
          for (p = 0; p < NPOOL; p++)
            if (!pool_used[p]) begin
              found = 1;
              break;
            end
          if (!found) begin
            o.status = ST_NOSPACE;
          end else begin
            pool_used[p] = 1;
            pool_base[p] = r.base_address;
            pool_bsize[p] = r.block_size;
            pool_bcount[p] = r.block_count[6:0];
            pool_common[p] = r.pool_kind != 0;
            pool_free[p] = '0;
            for (i = 0; i < r.block_count; i++) pool_free[p][i] = 1'b1;
            o.value = 25'(p);
          end
        end
      end
      ACT_DESTROY: begin
        if (!known_pool(r.pool_id)) o.status = ST_INVALID;
        else pool_used[r.pool_id] = 0;
      end
      ACT_GET: begin
        found = 0;
        p = 0;
        if (r.owner_id > OWNER_LIMIT) begin
          o.status = ST_INVALID;
        end else begin
          if (r.any_pool) begin
            for (p = 0; p < NPOOL; p++) begin
              if (!pool_used[p]) continue;
              if (r.block_size != 0 && r.block_size > pool_bsize[p]) continue;
              if (first_free_block(p) < pool_bcount[p]) begin
                found = 1;
                break;
              end
            end
          end else if (known_pool(r.pool_id)) begin
            p = r.pool_id;
            found = 1;
          end
          if (!found || (r.block_size != 0 && r.block_size > pool_bsize[p])) begin
            o.status = ST_INVALID;
          end else begin
            i = first_free_block(p);
            if (i >= pool_bcount[p]) begin
              o.status = ST_NOSPACE;
            end else begin
              pool_free[p][i] = 1'b0;
              o.value = 25'((p << 16) | i);
            end
          end
        end
      end
      ACT_RELEASE: begin
        if (r.handle > HANDLE_LIMIT || !known_pool(r.handle >> 16)) begin
          o.status = ST_INVALID;
        end else begin
          p = r.handle >> 16;
          if (r.handle[15:0] < pool_bcount[p]) pool_free[p][r.handle[5:0]] = 1'b1;
        end
      end
      ACT_A2H: begin
        found = 0;
        for (p = 0; p < NPOOL; p++) begin
          off = r.phys_address - pool_base[p];
          if (pool_used[p] && r.phys_address >= pool_base[p] &&
              off < pool_bsize[p] * pool_bcount[p]) begin
            found = 1;
            break;
          end
        end
        if (!found) o.status = ST_INVALID;
        else o.value = 25'((64'(p) << 16) | ((off / pool_bsize[p]) & 64'hffff));
      end
      ACT_H2A: begin
        if (r.handle > HANDLE_LIMIT || !known_pool(r.handle >> 16) ||
            r.handle[15:0] >= pool_bcount[r.handle >> 16]) begin
          o.status = ST_INVALID;
        end else begin
          p = r.handle >> 16;
          o.address_out = pool_base[p] + r.handle[15:0] * pool_bsize[p];
        end
      end
      ACT_H2P: begin
        if (r.handle > HANDLE_LIMIT) o.status = ST_INVALID;
        else o.value = 25'(r.handle >> 16);
      end
      default: begin
        if (!known_pool(r.pool_id)) begin
          o.status = ST_INVALID;
        end else begin
          p = r.pool_id;
          o.address_out = pool_base[p];
          o.size_out = pool_bsize[p];
          o.count_out = 16'(pool_bcount[p]);
          o.total_out = pool_bsize[p] * pool_bcount[p];
          o.is_common = pool_common[p];
        end
      end
    endcase
    return o;
  endfunction

  function automatic int random_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Sends one request; the prediction is taken at the accepting edge. The
  // wait before each raise keeps the drop of valid and the next raise apart.
  task automatic send_request(input req_t r, input bit gaps);
    int g;
    g = gaps ? random_gap() : 0;
    repeat (g + 1) @(posedge clk);
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_rsp.push_back(predict_pool_op(r));
    req_sent++;
    req_valid <= 1'b0;
  endtask

  // Response side: random gaps between ready cycles, plus a long hold-off.
  initial begin
    int g;
    rsp_ready = 1'b0;
    g = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        rsp_ready <= 1'b0;
      end else if (g > 0) begin
        rsp_ready <= 1'b0;
        g--;
      end else begin
        rsp_ready <= 1'b1;
        g = random_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      rsp_t e;
      if (pending_rsp.size() == 0) begin
        $display("MISMATCH unexpected response %p", rsp);
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.status !== e.status) report_mismatch("status", rsp.status, e.status);
        if (rsp.value !== e.value) report_mismatch("value", rsp.value, e.value);
        if (rsp.address_out !== e.address_out)
          report_mismatch("address_out", rsp.address_out, e.address_out);
        if (rsp.size_out !== e.size_out) report_mismatch("size_out", rsp.size_out, e.size_out);
        if (rsp.count_out !== e.count_out)
          report_mismatch("count_out", rsp.count_out, e.count_out);
        if (rsp.total_out !== e.total_out)
          report_mismatch("total_out", rsp.total_out, e.total_out);
        if (rsp.is_common !== e.is_common)
          report_mismatch("is_common", rsp.is_common, e.is_common);
      end
      rsp_seen++;
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("Watchdog expired after %0d idle cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic req_t noise_request();
    req_t r;
    r.action = 3'($urandom_range(0, 7));
    r.any_pool = 1'($urandom_range(0, 1));
    r.pool_id = 9'($urandom_range(0, 511));
    r.handle = $urandom;
    r.block_size = {$urandom, $urandom};
    r.block_count = 16'($urandom_range(0, 65535));
    r.pool_kind = 2'($urandom_range(0, 3));
    r.base_address = {$urandom, $urandom};
    r.phys_address = {$urandom, $urandom};
    r.owner_id = 8'($urandom_range(0, 255));
    return r;
  endfunction

  // Pick a pool id that is usually live.
  function automatic int pick_pool();
    int p;
    for (int n = 0; n < 4; n++) begin
      p = $urandom_range(0, NPOOL - 1);
      if (pool_used[p]) return p;
    end
    return $urandom_range(0, NPOOL + 2);
  endfunction

  function automatic req_t good_request();
    req_t r;
    int p;
    int k;
    r = noise_request();
    r.owner_id = 8'($urandom_range(0, OWNER_LIMIT));
    p = pick_pool();
    k = $urandom_range(0, 99);
    if (k < 12) begin
      r.action = ACT_CREATE;
      r.block_count = ($urandom_range(0, 7) == 0) ? 16'(NBLK) : 16'($urandom_range(1, 8));
      r.block_size = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} >> $urandom_range(6, 63)
                                                 : 64'(1 << $urandom_range(4, 12));
      if (r.block_size == 0) r.block_size = 1;
      r.base_address = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                   : 64'($urandom_range(0, 15)) << 20;
    end else if (k < 17) begin
      r.action = ACT_DESTROY;
      r.pool_id = 9'(p);
    end else if (k < 40) begin
      r.action = ACT_GET;
      r.pool_id = 9'(p);
      if ($urandom_range(0, 1)) r.block_size = 0;
      else if (p < NPOOL) r.block_size = pool_bsize[p] - $urandom_range(0, 1);
    end else if (k < 58) begin
      r.action = ACT_RELEASE;
      r.handle = (p << 16) | $urandom_range(0, 70);
    end else if (k < 70) begin
      r.action = ACT_A2H;
      if (p < NPOOL && pool_used[p])
        r.phys_address = pool_base[p] + pool_bsize[p] * $urandom_range(0, 64)
                         + $urandom_range(0, 3);
    end else if (k < 82) begin
      r.action = ACT_H2A;
      r.handle = (p << 16) | $urandom_range(0, 70);
    end else if (k < 88) begin
      r.action = ACT_H2P;
      r.handle = $urandom_range(0, 1) ? {7'd0, r.handle[24:0]} : r.handle;
    end else begin
      r.action = ACT_INFO;
      r.pool_id = 9'(p);
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4 * NPOOL + 2 * NBLK) @(posedge clk);
  endtask

  task automatic test_directed();
    req_t r;
    r = '0;
    r.action = ACT_INFO;
    send_request(r, 0);                         // unused pool
    r.action = ACT_CREATE;
    r.block_size = 64'hffff_ffff_ffff_ffff;
    r.block_count = 2;
    send_request(r, 0);                         // product overflows
    r.block_size = 0;
    send_request(r, 0);                         // zero size
    r.block_size = 16; r.block_count = 0;
    send_request(r, 0);                         // zero count
    r.block_count = NBLK + 1;
    send_request(r, 0);                         // too many blocks
    r.block_count = 16'hffff;
    send_request(r, 0);
    r.block_count = NBLK; r.block_size = 64'h1000; r.pool_kind = 2;
    r.base_address = 64'hffff_ffff_ffff_0000;
    send_request(r, 0);                         // pool at top of memory
    r.block_count = 1; r.block_size = 64'h0400_0000_0000_0000; r.pool_kind = 1;
    r.base_address = 0;
    send_request(r, 0);
    r = '0; r.action = ACT_INFO; r.pool_id = 0;
    send_request(r, 0);
    r.pool_id = 9'h1ff;
    send_request(r, 0);
    r = '0; r.action = ACT_GET; r.owner_id = 8'h18;
    send_request(r, 0);                         // bad owner
    r.owner_id = 8'hff;
    send_request(r, 0);
    r.owner_id = OWNER_LIMIT; r.pool_id = 1;
    send_request(r, 0);                         // takes the only block
    send_request(r, 0);                         // pool exhausted
    r.any_pool = 1; r.block_size = 64'hffff_ffff_ffff_ffff;
    send_request(r, 0);                         // nothing large enough
    r.block_size = 0;
    send_request(r, 0);
    r = '0; r.action = ACT_RELEASE; r.handle = 32'h0001_0005;
    send_request(r, 0);                         // index past count
    r.handle = 32'hffff_ffff;
    send_request(r, 0);
    r.action = ACT_H2A; r.handle = 32'h0000_003f;
    send_request(r, 0);                         // wraps past 2^64
    r.handle = 32'h0000_0040;
    send_request(r, 0);
    r.action = ACT_H2P; r.handle = HANDLE_LIMIT;
    send_request(r, 0);
    r.handle = HANDLE_LIMIT + 1;
    send_request(r, 0);
    r.action = ACT_A2H; r.phys_address = 64'hffff_ffff_ffff_ffff;
    send_request(r, 0);                         // last byte of memory, inside pool 0
    r.phys_address = 64'h0400_0000_0000_0000;
    send_request(r, 0);                         // one past pool 1
    r = '0; r.action = ACT_DESTROY; r.pool_id = 1;
    send_request(r, 0);
    wait_drained();
  endtask

  task automatic test_table_full();
    req_t r;
    r = good_request();
    r.action = ACT_CREATE; r.block_size = 32; r.block_count = 3;
    for (int n = 0; n < NPOOL + 2; n++) begin
      r.base_address = 64'(n) << 24;
      send_request(r, 1);
    end
    wait_drained();
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++)
      send_request(($urandom_range(0, 9) == 0) ? noise_request() : good_request(), 1);
  endtask

  // The response side stops while requests keep coming, so the block backs up.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      test_random(12);
    join
    wait_drained();
  endtask

  task automatic test_destroy_all();
    req_t r;
    r = '0;
    r.action = ACT_DESTROY;
    for (int p = 0; p < NPOOL; p++) begin
      r.pool_id = 9'(p);
      send_request(r, 1);
    end
    wait_drained();
  endtask

  initial begin
    errors = 0; rsp_seen = 0; req_sent = 0; idle_cycles = 0;
    hold_off = 0; timed_out = 0;
    for (int p = 0; p < NPOOL; p++) begin
      pool_used[p] = 0; pool_base[p] = 0; pool_bsize[p] = 0;
      pool_bcount[p] = 0; pool_common[p] = 0; pool_free[p] = 0;
    end
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_random(400);
    test_backpressure();
    test_destroy_all();
    test_random(580);
    wait_drained();

    $display("Covered %0d requests and %0d responses over every operation,", req_sent,
             rsp_seen);
    $display("including a full pool table and a long response stall.");
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
